@@ src/scpa_pkg.sv @@
package scpa_pkg;

    localparam int OFF_W       = 16;
    localparam int POOL_W      = 17;
    localparam int CLASS_SHIFT = 3;
    localparam int BCLASS_W    = 6;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [POOL_W-1:0] POOL_CAP    = 17'h10000;
    localparam logic [POOL_W-1:0] POOL_RESET  = 17'h10000;
    localparam logic [OFF_W-1:0]  START_RESET = 16'd1048;

    localparam logic REG_POOL_BYTES   = 1'b0;
    localparam logic REG_START_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_SIZE   = 3'd1,
        STAT_EXHAUSTED  = 3'd2,
        STAT_BAD_OFFSET = 3'd3,
        STAT_BAD_CLASS  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_BUMP,
        DSEL_POP
    } dsel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_LIST,
        S_ALLOC_POP,
        S_FREE_CLASS,
        S_FREE_LIST,
        S_FREE_CLEAR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    rd_meta;
        logic    meta_from_bc;
        logic    rd_bclass;
        logic    rd_link;
        logic    wr_bump;
        logic    wr_pop;
        logic    wr_free;
        logic    wr_clear;
        logic    res_set;
        status_t res_status;
        dsel_t   res_dsel;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_bad;
        logic hdr_bad;
        logic cnt_nonzero;
        logic bump_fits;
        logic pop_oob;
        logic bc_bad;
    } dp_stat_t;

endpackage

@@ src/scpa_ctrl.sv @@
module scpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  scpa_pkg::dp_stat_t stat,
    output scpa_pkg::dp_cmd_t  cmd
);
    import scpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   result_free;

    assign result_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (!stat.is_free && stat.size_bad)
                begin
                    state_next = S_RESULT;
                end
                else if (!stat.is_free)
                begin
                    state_next = S_ALLOC_LIST;
                end
                else if (stat.hdr_bad)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_FREE_CLASS;
                end
            end
            S_ALLOC_LIST:
            begin
                state_next = stat.cnt_nonzero ? S_ALLOC_POP : S_RESULT;
            end
            S_ALLOC_POP:
            begin
                state_next = S_RESULT;
            end
            S_FREE_CLASS:
            begin
                state_next = stat.bc_bad ? S_RESULT : S_FREE_LIST;
            end
            S_FREE_LIST:
            begin
                state_next = S_FREE_CLEAR;
            end
            S_FREE_CLEAR:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (result_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = STAT_OK;
        cmd.res_dsel   = DSEL_ZERO;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                priority if (!stat.is_free && stat.size_bad)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_BAD_SIZE;
                end
                else if (!stat.is_free)
                begin
                    cmd.rd_meta = 1'b1;
                end
                else if (stat.hdr_bad)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_BAD_OFFSET;
                end
                else
                begin
                    cmd.rd_bclass = 1'b1;
                end
            end
            S_ALLOC_LIST:
            begin
                priority if (stat.cnt_nonzero)
                begin
                    cmd.rd_link = 1'b1;
                end
                else if (stat.bump_fits)
                begin
                    cmd.wr_bump    = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_dsel   = DSEL_BUMP;
                end
                else
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_EXHAUSTED;
                end
            end
            S_ALLOC_POP:
            begin
                cmd.wr_pop  = 1'b1;
                cmd.res_set = 1'b1;
                if (stat.pop_oob)
                begin
                    cmd.res_status = STAT_EXHAUSTED;
                end
                else
                begin
                    cmd.res_status = STAT_OK;
                    cmd.res_dsel   = DSEL_POP;
                end
            end
            S_FREE_CLASS:
            begin
                if (stat.bc_bad)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_BAD_CLASS;
                end
                else
                begin
                    cmd.rd_meta      = 1'b1;
                    cmd.meta_from_bc = 1'b1;
                end
            end
            S_FREE_LIST:
            begin
                cmd.wr_free = 1'b1;
            end
            S_FREE_CLEAR:
            begin
                cmd.wr_clear = 1'b1;
                cmd.res_set  = 1'b1;
            end
            S_RESULT:
            begin
                cmd.out_load = result_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/scpa_dp.sv @@
module scpa_dp #(
    parameter int NUM_CLASSES   = 64,
    parameter int HEADER_BYTES  = 16,
    parameter int TRAILER_BYTES = 4,
    parameter int POOL_WORDS    = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [scpa_pkg::POOL_W-1:0]   pool_bytes_cfg,
    input  logic                          bump_load,
    input  logic [scpa_pkg::OFF_W-1:0]    bump_load_val,
    input  scpa_pkg::dp_cmd_t             cmd,
    output scpa_pkg::dp_stat_t            stat,
    input  logic                          command,
    input  logic [scpa_pkg::OFF_W-1:0]    req_bytes,
    input  logic [scpa_pkg::OFF_W-1:0]    free_offset,
    output logic [2:0]                    status,
    output logic [scpa_pkg::OFF_W-1:0]    result_offset,
    output logic                          reused,
    output logic [scpa_pkg::POOL_W-1:0]   unbumped_bytes
);
    import scpa_pkg::*;

    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW    = $clog2(POOL_WORDS);
    localparam int WW    = OFF_W - 2;
    localparam int CFW   = OFF_W - CLASS_SHIFT;
    localparam int SIZEW = 12;

    // Reduces a byte offset to its word slot, wrapping modulo the word count.
    function automatic logic [AW-1:0] word_of(input logic [OFF_W-1:0] off);
        logic [WW-1:0] r;
        r = off[OFF_W-1:2];
        for (int k = 5; k >= 0; k--)
        begin
            if (32'(r) >= (POOL_WORDS << k))
            begin
                r = r - WW'(POOL_WORDS << k);
            end
        end
        return AW'(r);
    endfunction

    logic [OFF_W-1:0]    cnt_mem   [NUM_CLASSES];
    logic [OFF_W-1:0]    head_mem  [NUM_CLASSES];
    logic [OFF_W-1:0]    tail_mem  [NUM_CLASSES];
    logic [BCLASS_W-1:0] bclass_mem[POOL_WORDS];
    logic [OFF_W-1:0]    link_mem  [POOL_WORDS];

    logic [NUM_CLASSES-1:0] vld_reg;
    logic                   vld_rd_reg;
    logic [OFF_W-1:0]       cnt_rd_reg;
    logic [OFF_W-1:0]       head_rd_reg;
    logic [OFF_W-1:0]       tail_rd_reg;
    logic [OFF_W-1:0]       link_rd_reg;
    logic [BCLASS_W-1:0]    bc_rd_reg;

    logic                   free_cmd_reg;
    logic                   size_bad_reg;
    logic                   hdr_bad_reg;
    logic [CW-1:0]          cls_reg;
    logic [BCLASS_W-1:0]    cls6_reg;
    logic [OFF_W-1:0]       blk_reg;
    logic [POOL_W-1:0]      bump_reg;

    status_t                res_status_reg;
    logic [OFF_W-1:0]       res_data_reg;
    logic                   res_reused_reg;
    status_t                out_status_reg;
    logic [OFF_W-1:0]       out_data_reg;
    logic                   out_reused_reg;
    logic [POOL_W-1:0]      out_unbumped_reg;

    logic [OFF_W-1:0]       req_m1;
    logic [CFW-1:0]         cls_full;
    logic [CW-1:0]          meta_addr;
    logic [POOL_W-1:0]      eff_pool;
    logic [OFF_W-1:0]       cnt_eff;
    logic [SIZEW-1:0]       blk_size;
    logic [POOL_W:0]        bump_sum;
    logic [POOL_W-1:0]      bump_next;
    logic [POOL_W-1:0]      unbumped;
    logic [OFF_W-1:0]       res_data;
    logic                   link_we;
    logic [AW-1:0]          link_waddr;
    logic [OFF_W-1:0]       link_wdata;

    assign req_m1    = req_bytes - 16'd1;
    assign cls_full  = CFW'(req_m1 >> CLASS_SHIFT);
    assign meta_addr = cmd.meta_from_bc ? CW'(bc_rd_reg) : cls_reg;
    assign eff_pool  = (pool_bytes_cfg > POOL_CAP) ? POOL_CAP : pool_bytes_cfg;
    assign cnt_eff   = vld_rd_reg ? cnt_rd_reg : '0;
    assign blk_size  = SIZEW'(HEADER_BYTES)
                       + ((SIZEW'(cls_reg) + SIZEW'(1)) << CLASS_SHIFT);
    assign bump_sum  = (POOL_W+1)'(bump_reg) + (POOL_W+1)'(blk_size);
    assign bump_next = POOL_W'(bump_sum + (POOL_W+1)'(TRAILER_BYTES));
    assign unbumped  = (bump_reg >= eff_pool) ? '0 : eff_pool - bump_reg;

    assign stat.is_free     = free_cmd_reg;
    assign stat.size_bad    = size_bad_reg;
    assign stat.hdr_bad     = hdr_bad_reg;
    assign stat.cnt_nonzero = (cnt_eff != '0);
    assign stat.bump_fits   = (bump_sum <= (POOL_W+1)'(eff_pool));
    assign stat.pop_oob     = ((POOL_W'(head_rd_reg) + POOL_W'(HEADER_BYTES)) > eff_pool);
    assign stat.bc_bad      = (32'(bc_rd_reg) >= NUM_CLASSES);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            free_cmd_reg <= command;
            size_bad_reg <= (req_bytes == '0) || (32'(cls_full) >= NUM_CLASSES);
            cls_reg      <= CW'(cls_full);
            cls6_reg     <= BCLASS_W'(cls_full);
            blk_reg      <= free_offset - OFF_W'(HEADER_BYTES);
            hdr_bad_reg  <= (free_offset < OFF_W'(HEADER_BYTES));
        end
        else if (cmd.meta_from_bc)
        begin
            cls_reg <= CW'(bc_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg <= POOL_W'(START_RESET);
        end
        else if (bump_load)
        begin
            bump_reg <= POOL_W'(bump_load_val);
        end
        else if (cmd.wr_bump)
        begin
            bump_reg <= bump_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr_pop || cmd.wr_free)
        begin
            vld_reg[cls_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_meta)
        begin
            cnt_rd_reg <= cnt_mem[meta_addr];
            vld_rd_reg <= vld_reg[meta_addr];
        end
        if (cmd.wr_pop)
        begin
            cnt_mem[cls_reg] <= cnt_eff - 16'd1;
        end
        else if (cmd.wr_free)
        begin
            cnt_mem[cls_reg] <= cnt_eff + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_meta)
        begin
            head_rd_reg <= head_mem[meta_addr];
        end
        if (cmd.wr_pop)
        begin
            head_mem[cls_reg] <= link_rd_reg;
        end
        else if (cmd.wr_free && (cnt_eff == '0))
        begin
            head_mem[cls_reg] <= blk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_meta)
        begin
            tail_rd_reg <= tail_mem[meta_addr];
        end
        if (cmd.wr_free)
        begin
            tail_mem[cls_reg] <= blk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_bclass)
        begin
            bc_rd_reg <= bclass_mem[word_of(blk_reg)];
        end
        if (cmd.wr_bump)
        begin
            bclass_mem[word_of(bump_reg[OFF_W-1:0])] <= cls6_reg;
        end
    end

    assign link_we    = cmd.wr_clear || (cmd.wr_free && (cnt_eff != '0));
    assign link_waddr = cmd.wr_clear ? word_of(blk_reg) : word_of(tail_rd_reg);
    assign link_wdata = cmd.wr_clear ? '0 : blk_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_link)
        begin
            link_rd_reg <= link_mem[word_of(head_rd_reg)];
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_comb
    begin
        unique case (cmd.res_dsel)
            DSEL_BUMP: res_data = bump_reg[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
            DSEL_POP:  res_data = head_rd_reg + OFF_W'(HEADER_BYTES);
            default:   res_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= res_data;
            res_reused_reg <= (cmd.res_dsel == DSEL_POP);
        end
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_data_reg     <= res_data_reg;
            out_reused_reg   <= res_reused_reg;
            out_unbumped_reg <= unbumped;
        end
    end

    assign status         = out_status_reg;
    assign result_offset  = out_data_reg;
    assign reused         = out_reused_reg;
    assign unbumped_bytes = out_unbumped_reg;

endmodule

@@ src/size_class_pool_allocator.sv @@
// An item goes from decode to the result state directly for a bad size or a bad offset,
// via ALLOC_LIST for a bump allocation, FREE_CLASS for a bad class, ALLOC_LIST and
// ALLOC_POP for a free-list allocation, or FREE_CLASS, FREE_LIST and FREE_CLEAR
// for a free. One item is in flight; the next is taken after the result is registered.
// Reset clears the controller, the configuration registers, the class count valid bits
// and the bump pointer; the block pool and free-list memories hold no reset value.
module size_class_pool_allocator #(
    parameter int NUM_CLASSES   = 64,
    parameter int HEADER_BYTES  = 16,
    parameter int TRAILER_BYTES = 4,
    parameter int POOL_WORDS    = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [scpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [scpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [scpa_pkg::OFF_W-1:0]    req_bytes,
    input  logic [scpa_pkg::OFF_W-1:0]    free_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [scpa_pkg::OFF_W-1:0]    result_offset,
    output logic                          reused,
    output logic [scpa_pkg::POOL_W-1:0]   unbumped_bytes
);
    import scpa_pkg::*;

    logic [POOL_W-1:0] pool_reg;
    logic [OFF_W-1:0]  start_reg;
    logic              cfg_wr;
    logic              start_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign start_wr = cfg_wr && (paddr[2] == REG_START_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= POOL_RESET;
            start_reg <= START_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_POOL_BYTES)
            begin
                pool_reg <= pwdata[POOL_W-1:0];
            end
            else
            begin
                start_reg <= pwdata[OFF_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_START_OFFSET) ? PDATA_W'(start_reg) : PDATA_W'(pool_reg);

    scpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    scpa_dp #(
        .NUM_CLASSES   (NUM_CLASSES),
        .HEADER_BYTES  (HEADER_BYTES),
        .TRAILER_BYTES (TRAILER_BYTES),
        .POOL_WORDS    (POOL_WORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .pool_bytes_cfg (pool_reg),
        .bump_load      (start_wr),
        .bump_load_val  (pwdata[OFF_W-1:0]),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .req_bytes      (req_bytes),
        .free_offset    (free_offset),
        .status         (status),
        .result_offset  (result_offset),
        .reused         (reused),
        .unbumped_bytes (unbumped_bytes)
    );

endmodule
